### sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clock edge outside reset.
`define ASSERT_IMPL(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Check a property in the cycle after a condition.
`define ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

### sv/fpfa_pkg.sv
package fpfa_pkg;

    localparam int PARTITIONS = 16;
    localparam int SIZE_WIDTH = 16;

    localparam int ADDR_W = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
    localparam int CNT_W  = $clog2(PARTITIONS + 1);

    localparam int MODE_W   = 1;
    localparam int PIDX_W   = 4;
    localparam int FIELD_W  = 16;
    localparam int POLICY_W = 2;
    localparam int PCOUNT_W = 5;
    localparam int CFG_W    = 5;
    localparam int CFG_IDX_W = 1;

    localparam logic [MODE_W-1:0] MODE_LOAD    = 1'b0;
    localparam logic [MODE_W-1:0] MODE_REQUEST = 1'b1;

    localparam logic [POLICY_W-1:0] FIT_FIRST = 2'd0;
    localparam logic [POLICY_W-1:0] FIT_BEST  = 2'd1;
    localparam logic [POLICY_W-1:0] FIT_WORST = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_FIT_POLICY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PART_COUNT = 1'd1;

    localparam logic [PCOUNT_W-1:0] PART_COUNT_RESET = 5'd16;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CHARGE
    } state_t;

    typedef struct packed {
        logic                  we;
        logic [ADDR_W-1:0]     waddr;
        logic [SIZE_WIDTH-1:0] wdata;
        logic                  re;
        logic [ADDR_W-1:0]     raddr;
    } mem_req_t;

    typedef struct packed {
        logic [POLICY_W-1:0] policy;
        logic [CNT_W-1:0]    active_cnt;
    } cfg_t;

    typedef struct packed {
        logic                  valid;
        logic                  granted;
        logic [PIDX_W-1:0]     chosen_partition;
        logic [SIZE_WIDTH-1:0] size_before;
        logic [SIZE_WIDTH-1:0] size_after;
    } res_t;

endpackage

### sv/fpfa_if.sv
interface fpfa_item_if;
    import fpfa_pkg::*;

    logic               valid;
    logic               ready;
    logic [MODE_W-1:0]  mode;
    logic [PIDX_W-1:0]  partition_index;
    logic [FIELD_W-1:0] size_value;

    modport source (output valid, output mode, output partition_index, output size_value,
                    input ready);
    modport sink   (input valid, input mode, input partition_index, input size_value,
                    output ready);
endinterface

interface fpfa_result_if;
    import fpfa_pkg::*;

    logic               valid;
    logic               ready;
    logic               granted;
    logic [PIDX_W-1:0]  chosen_partition;
    logic [FIELD_W-1:0] size_before;
    logic [FIELD_W-1:0] size_after;

    modport source (output valid, output granted, output chosen_partition,
                    output size_before, output size_after, input ready);
    modport sink   (input valid, input granted, input chosen_partition,
                    input size_before, input size_after, output ready);
endinterface

### sv/fpfa_mem.sv
module fpfa_mem (
    input  logic                           clk,
    input  fpfa_pkg::mem_req_t             mem_req,
    output logic [fpfa_pkg::SIZE_WIDTH-1:0] rdata
);
    import fpfa_pkg::*;

    logic [SIZE_WIDTH-1:0] sizes_mem [PARTITIONS];
    logic [SIZE_WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (mem_req.we)
        begin
            sizes_mem[mem_req.waddr] <= mem_req.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_req.re)
        begin
            rdata_reg <= sizes_mem[mem_req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### sv/fpfa_ctrl.sv
module fpfa_ctrl (
    input  logic                            clk,
    input  logic                            rst_n,
    input  fpfa_pkg::cfg_t                  cfg,
    input  logic                            item_valid,
    output logic                            item_ready,
    input  logic [fpfa_pkg::MODE_W-1:0]     item_mode,
    input  logic [fpfa_pkg::PIDX_W-1:0]     item_pidx,
    input  logic [fpfa_pkg::FIELD_W-1:0]    item_size,
    output fpfa_pkg::res_t                  res,
    input  logic                            res_free,
    output fpfa_pkg::mem_req_t              mem_req,
    input  logic [fpfa_pkg::SIZE_WIDTH-1:0] rdata
);
    import fpfa_pkg::*;

    state_t                state_reg,     state_next;
    logic [CNT_W-1:0]      rd_idx_reg,    rd_idx_next;
    logic                  cmp_vld_reg,   cmp_vld_next;
    logic [ADDR_W-1:0]     cmp_idx_reg,   cmp_idx_next;
    logic                  found_reg,     found_next;
    logic [ADDR_W-1:0]     pick_idx_reg,  pick_idx_next;
    logic [SIZE_WIDTH-1:0] pick_size_reg, pick_size_next;
    logic [SIZE_WIDTH-1:0] req_size_reg,  req_size_next;

    logic                  fits;
    logic                  take;
    logic [SIZE_WIDTH-1:0] charged;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cmp_vld_reg <= 1'b0;
            found_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cmp_vld_reg <= cmp_vld_next;
            found_reg   <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg    <= rd_idx_next;
        cmp_idx_reg   <= cmp_idx_next;
        pick_idx_reg  <= pick_idx_next;
        pick_size_reg <= pick_size_next;
        req_size_reg  <= req_size_next;
    end

    // shared comparator: one table entry per cycle
    always_comb
    begin
        fits = cmp_vld_reg && (rdata >= req_size_reg);
        take = 1'b0;
        if (fits)
        begin
            if (!found_reg)
            begin
                take = 1'b1;
            end
            else if (cfg.policy == FIT_BEST)
            begin
                take = rdata < pick_size_reg;
            end
            else if (cfg.policy == FIT_WORST)
            begin
                take = rdata > pick_size_reg;
            end
        end
    end

    assign charged = pick_size_reg - req_size_reg;

    always_comb
    begin
        state_next     = state_reg;
        rd_idx_next    = rd_idx_reg;
        cmp_vld_next   = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        found_next     = found_reg;
        pick_idx_next  = pick_idx_reg;
        pick_size_next = pick_size_reg;
        req_size_next  = req_size_reg;
        item_ready     = 1'b0;
        mem_req        = '0;
        res            = '0;

        case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    if (item_mode == MODE_LOAD)
                    begin
                        if (32'(item_pidx) < 32'(PARTITIONS))
                        begin
                            mem_req.we    = 1'b1;
                            mem_req.waddr = ADDR_W'(item_pidx);
                            mem_req.wdata = SIZE_WIDTH'(item_size);
                        end
                    end
                    else
                    begin
                        req_size_next = SIZE_WIDTH'(item_size);
                        rd_idx_next   = '0;
                        found_next    = 1'b0;
                        state_next    = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                if (take)
                begin
                    found_next     = 1'b1;
                    pick_idx_next  = cmp_idx_reg;
                    pick_size_next = rdata;
                end
                if (rd_idx_reg < cfg.active_cnt)
                begin
                    mem_req.re   = 1'b1;
                    mem_req.raddr = rd_idx_reg[ADDR_W-1:0];
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = rd_idx_reg[ADDR_W-1:0];
                    rd_idx_next  = rd_idx_reg + CNT_W'(1);
                end
                else if (!cmp_vld_reg)
                begin
                    state_next = ST_CHARGE;
                end
            end

            ST_CHARGE:
            begin
                res.valid = 1'b1;
                if (found_reg)
                begin
                    res.granted          = 1'b1;
                    res.chosen_partition = PIDX_W'(pick_idx_reg);
                    res.size_before      = pick_size_reg;
                    res.size_after       = charged;
                end
                if (res_free)
                begin
                    if (found_reg)
                    begin
                        mem_req.we    = 1'b1;
                        mem_req.waddr = pick_idx_reg;
                        mem_req.wdata = charged;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### sv/fixed_partition_fit_allocator.sv
// Fixed-partition fit allocator.
// Items arrive on the item channel (valid/ready): mode 0 loads size_value into
// partition partition_index, mode 1 requests size_value from the partitions in use.
// Each request yields one item on the result channel: granted, chosen_partition,
// size_before and size_after; a refused request reports all zeros. Loads yield none.
// Policy (first, best or worst fit) and the partition count come from the plain
// write port cfg_we / cfg_index / cfg_wdata. The user must write it only while the
// block is idle; the block itself does not enforce this. A request scans the table
// through one comparator, one entry per cycle over a registered memory read, and
// holds the item channel until its result enters the output register; the result
// becomes visible as the item channel is freed again.
// The result sits in an output register: the next item may be accepted while it
// waits, and a later request waits in its final step until that register is taken.
// Reset clears the controller, the output valid flag, fit_policy to first fit and
// partition_count to 16. The size table is not cleared; load a partition before a
// request can reach it.
module fixed_partition_fit_allocator (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [fpfa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fpfa_pkg::CFG_W-1:0]        cfg_wdata,
    fpfa_item_if.sink                         item,
    fpfa_result_if.source                     result
);
    import fpfa_pkg::*;

    `include "assert_macros.svh"

    logic [POLICY_W-1:0]   fit_policy_reg, fit_policy_next;
    logic [PCOUNT_W-1:0]   part_count_reg, part_count_next;
    logic                  out_valid_reg,  out_valid_next;
    res_t                  out_reg,        out_next;

    cfg_t                  cfg;
    res_t                  res;
    logic                  res_free;
    mem_req_t              mem_req;
    logic [SIZE_WIDTH-1:0] rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fit_policy_reg <= FIT_FIRST;
            part_count_reg <= PART_COUNT_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            fit_policy_reg <= fit_policy_next;
            part_count_reg <= part_count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    always_comb
    begin
        fit_policy_next = fit_policy_reg;
        part_count_next = part_count_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_FIT_POLICY: fit_policy_next = cfg_wdata[POLICY_W-1:0];
                REG_PART_COUNT: part_count_next = cfg_wdata[PCOUNT_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        cfg.policy     = fit_policy_reg;
        cfg.active_cnt = (32'(part_count_reg) > 32'(PARTITIONS)) ? CNT_W'(PARTITIONS)
                                                                 : CNT_W'(part_count_reg);
    end

    // hold the result until taken
    assign res_free = !out_valid_reg || result.ready;

    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (res.valid && res_free)
        begin
            out_next       = res;
            out_valid_next = 1'b1;
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.granted          = out_reg.granted;
    assign result.chosen_partition = out_reg.chosen_partition;
    assign result.size_before      = FIELD_W'(out_reg.size_before);
    assign result.size_after       = FIELD_W'(out_reg.size_after);

    fpfa_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (item.valid),
        .item_ready (item.ready),
        .item_mode  (item.mode),
        .item_pidx  (item.partition_index),
        .item_size  (item.size_value),
        .res        (res),
        .res_free   (res_free),
        .mem_req    (mem_req),
        .rdata      (rdata)
    );

    fpfa_mem u_mem (
        .clk     (clk),
        .mem_req (mem_req),
        .rdata   (rdata)
    );

    `ASSERT_IMPL(a_refused_zero, result.valid && !result.granted,
        result.chosen_partition == '0 && result.size_before == '0 && result.size_after == '0,
        "refused item carries nonzero fields")
    `ASSERT_IMPL(a_after_le_before, result.valid && result.granted,
        result.size_after <= result.size_before, "charged size grew")
    `ASSERT_IMPL(a_pick_in_use, result.valid && result.granted,
        32'(result.chosen_partition) < 32'(PARTITIONS), "grant outside the table")
    `ASSERT_NEXT(a_busy_after_request,
        item.valid && item.ready && item.mode == MODE_REQUEST,
        !item.ready, "request accepted while scan in progress")

endmodule

### verif/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import fpfa_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = 24;
    localparam int LONG_HOLD     = 400;
    localparam int LIMIT_CYCLES  = 400000;

    localparam logic [POLICY_W-1:0] FIT_UNUSED = 2'd3;

    typedef struct packed {
        logic                  granted;
        logic [PIDX_W-1:0]     chosen;
        logic [SIZE_WIDTH-1:0] prior;
        logic [SIZE_WIDTH-1:0] after;
    } grant_t;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  reg_sel;
        logic [MODE_W-1:0]     mode;
        logic [PIDX_W-1:0]     pidx;
        logic [FIELD_W-1:0]    size;
        logic                  typed;
        grant_t                want;
    } stim_row_t;

    typedef struct packed {
        logic [POLICY_W-1:0] policy;
        logic [PCOUNT_W-1:0] count;
        logic [15:0]         items;
        logic                send_gaps;
        logic                sink_gaps;
        logic                long_hold;
    } phase_t;

    localparam stim_row_t DIRECTED_ROWS [23] = '{
        '{ROW_CFG,  REG_PART_COUNT, MODE_LOAD,    4'd0,  16'd4,      1'b0, '0},
        '{ROW_ITEM, REG_FIT_POLICY, MODE_LOAD,    4'd0,  16'hFFFF,   1'b0, '0},
        '{ROW_ITEM, REG_FIT_POLICY, MODE_LOAD,    4'd1,  16'd0,      1'b0, '0},
        '{ROW_ITEM, REG_FIT_POLICY, MODE_LOAD,    4'd2,  16'd100,    1'b0, '0},
        '{ROW_ITEM, REG_FIT_POLICY, MODE_LOAD,    4'd3,  16'd50,     1'b0, '0},
        '{ROW_ITEM, REG_FIT_POLICY, MODE_LOAD,    4'd15, 16'h1234,   1'b0, '0},
        '{ROW_ITEM, REG_FIT_POLICY, MODE_REQUEST, 4'd0,  16'hFFFF,   1'b1,
          '{1'b1, 4'd0, 16'hFFFF, 16'd0}},
        '{ROW_ITEM, REG_FIT_POLICY, MODE_REQUEST, 4'd15, 16'hFFFF,   1'b1,
          '{1'b0, 4'd0, 16'd0, 16'd0}},
        '{ROW_ITEM, REG_FIT_POLICY, MODE_REQUEST, 4'd5,  16'd0,      1'b1,
          '{1'b1, 4'd0, 16'd0, 16'd0}},
        '{ROW_ITEM, REG_FIT_POLICY, MODE_REQUEST, 4'd0,  16'd60,     1'b1,
          '{1'b1, 4'd2, 16'd100, 16'd40}},
        '{ROW_CFG,  REG_FIT_POLICY, MODE_LOAD,    4'd0,  16'(FIT_BEST), 1'b0, '0},
        '{ROW_ITEM, REG_FIT_POLICY, MODE_LOAD,    4'd0,  16'd20,     1'b0, '0},
        '{ROW_ITEM, REG_FIT_POLICY, MODE_LOAD,    4'd1,  16'd30,     1'b0, '0},
        '{ROW_ITEM, REG_FIT_POLICY, MODE_LOAD,    4'd2,  16'd10,     1'b0, '0},
        '{ROW_ITEM, REG_FIT_POLICY, MODE_REQUEST, 4'd10, 16'd15,     1'b0, '0},
        '{ROW_ITEM, REG_FIT_POLICY, MODE_REQUEST, 4'd0,  16'd10,     1'b0, '0},
        '{ROW_CFG,  REG_FIT_POLICY, MODE_LOAD,    4'd0,  16'(FIT_WORST), 1'b0, '0},
        '{ROW_ITEM, REG_FIT_POLICY, MODE_LOAD,    4'd1,  16'd50,     1'b0, '0},
        '{ROW_ITEM, REG_FIT_POLICY, MODE_REQUEST, 4'd3,  16'd1,      1'b0, '0},
        '{ROW_CFG,  REG_FIT_POLICY, MODE_LOAD,    4'd0,  16'(FIT_UNUSED), 1'b0, '0},
        '{ROW_ITEM, REG_FIT_POLICY, MODE_REQUEST, 4'd7,  16'd1,      1'b0, '0},
        '{ROW_CFG,  REG_PART_COUNT, MODE_LOAD,    4'd0,  16'd0,      1'b0, '0},
        '{ROW_ITEM, REG_FIT_POLICY, MODE_REQUEST, 4'd15, 16'd0,      1'b1,
          '{1'b0, 4'd0, 16'd0, 16'd0}}
    };

    localparam phase_t PHASE_PLAN [10] = '{
        '{FIT_FIRST,  5'd16, 16'd130, 1'b1, 1'b1, 1'b0},
        '{FIT_BEST,   5'd16, 16'd130, 1'b1, 1'b0, 1'b0},
        '{FIT_WORST,  5'd16, 16'd130, 1'b0, 1'b1, 1'b1},
        '{FIT_UNUSED, 5'd31, 16'd100, 1'b1, 1'b1, 1'b0},
        '{FIT_BEST,   5'd1,  16'd80,  1'b1, 1'b1, 1'b0},
        '{FIT_WORST,  5'd17, 16'd100, 1'b1, 1'b1, 1'b1},
        '{FIT_FIRST,  5'd0,  16'd40,  1'b1, 1'b1, 1'b0},
        '{FIT_BEST,   5'd15, 16'd100, 1'b0, 1'b0, 1'b0},
        '{FIT_WORST,  5'd3,  16'd100, 1'b1, 1'b1, 1'b0},
        '{FIT_FIRST,  5'd16, 16'd150, 1'b0, 1'b0, 1'b0}
    };

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;

    fpfa_item_if   item_ch ();
    fpfa_result_if res_ch ();

    fixed_partition_fit_allocator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .item      (item_ch),
        .result    (res_ch)
    );

    logic [SIZE_WIDTH-1:0] part_left [PARTITIONS] = '{default: '0};
    bit                    part_loaded [PARTITIONS];
    logic [POLICY_W-1:0]   fit_rule = FIT_FIRST;
    logic [PCOUNT_W-1:0]   parts_in_use = PART_COUNT_RESET;

    grant_t grant_queue [$];

    bit send_gaps;
    bit sink_gaps;
    int hold_requests;
    int errors;
    int cycles;
    int items_sent;
    int loads;
    int requests;
    int grants;
    int checked;

    initial
    begin
        clk = 1'b0;
    end

    always #CLK_HALF clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= LIMIT_CYCLES)
        begin
            $error("timeout after %0d cycles, %0d results outstanding", cycles,
                   grant_queue.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic bit charge_partition(input logic [MODE_W-1:0] m,
                                            input logic [PIDX_W-1:0] p,
                                            input logic [FIELD_W-1:0] s,
                                            output grant_t g);
        int  limit;
        int  pick;
        bit  found;
        g = '0;
        if (m == MODE_LOAD)
        begin
            part_left[p]   = s;
            part_loaded[p] = 1'b1;
            return 1'b0;
        end
        limit = (parts_in_use > PARTITIONS) ? PARTITIONS : int'(parts_in_use);
        found = 1'b0;
        pick  = 0;
        for (int i = 0; i < limit; i++)
        begin
            if (part_left[i] >= s)
            begin
                if (!found)
                begin
                    found = 1'b1;
                    pick  = i;
                end
                else if (fit_rule == FIT_BEST && part_left[i] < part_left[pick])
                begin
                    pick = i;
                end
                else if (fit_rule == FIT_WORST && part_left[i] > part_left[pick])
                begin
                    pick = i;
                end
            end
        end
        if (found)
        begin
            g.granted       = 1'b1;
            g.chosen        = pick[PIDX_W-1:0];
            g.prior         = part_left[pick];
            part_left[pick] = part_left[pick] - s;
            g.after         = part_left[pick];
        end
        return 1'b1;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (got_v !== want_v)
        begin
            $error("%s: expected %0d, actual %0d", name, want_v, got_v);
            errors++;
        end
    endtask

    task automatic send_item(input logic [MODE_W-1:0] m, input logic [PIDX_W-1:0] p,
                             input logic [FIELD_W-1:0] s, input bit typed,
                             input grant_t typed_want);
        grant_t g;
        if (send_gaps && $urandom_range(0, 7) == 0)
        begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        item_ch.valid           <= 1'b1;
        item_ch.mode            <= m;
        item_ch.partition_index <= p;
        item_ch.size_value      <= s;
        @(posedge clk);
        while (item_ch.ready !== 1'b1)
        begin
            @(posedge clk);
        end
        items_sent++;
        if (charge_partition(m, p, s, g))
        begin
            requests++;
            if (g.granted)
            begin
                grants++;
            end
            grant_queue.push_back(typed ? typed_want : g);
        end
        else
        begin
            loads++;
        end
    endtask

    // hold until every result is back, then let any load drain
    task automatic wait_idle();
        while (grant_queue.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] sel, input logic [CFG_W-1:0] val);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= sel;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (sel == REG_FIT_POLICY)
        begin
            fit_rule = val[POLICY_W-1:0];
        end
        else
        begin
            parts_in_use = val;
        end
    endtask

    always @(posedge clk)
    begin : result_sink
        grant_t got;
        grant_t want;
        int     stall_left;
        int     hold_served;
        if (rst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
        begin
            got = '{res_ch.granted, res_ch.chosen_partition, res_ch.size_before,
                    res_ch.size_after};
            if (grant_queue.size() == 0)
            begin
                $error("result item with no expectation waiting");
                errors++;
            end
            else
            begin
                want = grant_queue.pop_front();
                checked++;
                check_field("granted", 32'(want.granted), 32'(got.granted));
                check_field("chosen_partition", 32'(want.chosen), 32'(got.chosen));
                check_field("size_before", 32'(want.prior), 32'(got.prior));
                check_field("size_after", 32'(want.after), 32'(got.after));
            end
        end
        if (stall_left > 0)
        begin
            stall_left--;
            res_ch.ready <= 1'b0;
        end
        else if (hold_served != hold_requests)
        begin
            hold_served  = hold_requests;
            stall_left   = LONG_HOLD - 1;
            res_ch.ready <= 1'b0;
        end
        else if (sink_gaps && $urandom_range(0, 9) == 0)
        begin
            stall_left   = $urandom_range(0, 12);
            res_ch.ready <= 1'b0;
        end
        else
        begin
            res_ch.ready <= 1'b1;
        end
    end

    initial
    begin : stimulus
        stim_row_t            row;
        phase_t               plan;
        int                   active;
        int unsigned          roll;
        logic [MODE_W-1:0]    m;
        logic [PIDX_W-1:0]    p;
        logic [FIELD_W-1:0]   s;

        rst_n                   = 1'b0;
        cfg_we                  = 1'b0;
        cfg_index               = '0;
        cfg_wdata               = '0;
        item_ch.valid           = 1'b0;
        item_ch.mode            = MODE_LOAD;
        item_ch.partition_index = '0;
        item_ch.size_value      = '0;
        res_ch.ready            = 1'b0;
        send_gaps               = 1'b1;
        sink_gaps               = 1'b1;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < $size(DIRECTED_ROWS); r++)
        begin
            row = DIRECTED_ROWS[r];
            if (row.kind == ROW_CFG)
            begin
                item_ch.valid <= 1'b0;
                write_reg(row.reg_sel, row.size[CFG_W-1:0]);
            end
            else
            begin
                send_item(row.mode, row.pidx, row.size, row.typed, row.want);
            end
        end
        item_ch.valid <= 1'b0;

        for (int ph = 0; ph < $size(PHASE_PLAN); ph++)
        begin
            plan = PHASE_PLAN[ph];
            write_reg(REG_FIT_POLICY, CFG_W'(plan.policy));
            write_reg(REG_PART_COUNT, plan.count);
            send_gaps = plan.send_gaps;
            sink_gaps = plan.sink_gaps;
            active    = (plan.count > PARTITIONS) ? PARTITIONS : int'(plan.count);
            // fill every partition in use that has never been loaded
            for (int i = 0; i < active; i++)
            begin
                if (!part_loaded[i])
                begin
                    send_item(MODE_LOAD, i[PIDX_W-1:0], FIELD_W'($urandom_range(0, 65535)),
                              1'b0, '0);
                end
            end
            for (int n = 0; n < plan.items; n++)
            begin
                if (plan.long_hold && n == plan.items / 2)
                begin
                    hold_requests <= hold_requests + 1;
                end
                p    = PIDX_W'($urandom_range(0, 15));
                roll = $urandom_range(0, 9);
                if ($urandom_range(0, 9) < 3)
                begin
                    m = MODE_LOAD;
                    s = (roll == 0) ? '0 : (roll == 1) ? '1 :
                        FIELD_W'($urandom_range(0, 65535));
                end
                else
                begin
                    m = MODE_REQUEST;
                    s = (roll == 0) ? '0 : (roll == 1) ? '1 :
                        (roll == 2) ? FIELD_W'($urandom_range(0, 65535)) :
                        FIELD_W'($urandom_range(1, 3000));
                end
                send_item(m, p, s, 1'b0, '0);
            end
            item_ch.valid <= 1'b0;
        end

        wait_idle();
        $display("Run covered %0d items (%0d loads, %0d requests): %0d granted, %0d refused.",
                 items_sent, loads, requests, grants, requests - grants);
        $display("Checked %0d results over %0d phases of policy and partition count settings.",
                 checked, $size(PHASE_PLAN) + 1);
        if (errors == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### files.f
+incdir+sv
sv/fpfa_pkg.sv
sv/fpfa_if.sv
sv/fpfa_mem.sv
sv/fpfa_ctrl.sv
sv/fixed_partition_fit_allocator.sv
verif/tb_top.sv
